FILE: hw/rtl/sjfo_pkg.sv
// ----------------------------------------------------------------------------
// sjfo_pkg - shared types and constants
// Fixed field widths and the control word broadcast along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sjfo_pkg;

	localparam int IN_TIME_W = 20;  // service_time port width
	localparam int IDX_W     = 6;   // stored person index (number minus 1)
	localparam int PERSON_W  = 7;
	localparam int WAIT_W    = 26;
	localparam int AVG_W     = 33;

	// broadcast to every cell each cycle
	typedef struct packed {
		logic load;   // insert the new word this cycle
		logic drain;  // shift the chain one place toward cell 0
	} cell_ctrl_t;

endpackage : sjfo_pkg

`default_nettype wire

FILE: hw/rtl/shortest_job_first_order_top.sv
// ----------------------------------------------------------------------------
// shortest_job_first_order_top - stable shortest-time-first ordering
// Loads one service time per cycle into a sorted cell chain; on the final
// word drains the chain in ascending order with waits and the rounded average.
// ----------------------------------------------------------------------------
// Load: one word per cycle, busy stays low while loading.
// After the final word: busy until the average is out; results for the
// first n-1 people come one per cycle, the last one after the bit-serial
// divider forms the NUM_W-bit quotient (NUM_W = 41 at default widths).
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset clears the count, the overflow mark and the sequencer; cells are
// left as they are.
`default_nettype none

module shortest_job_first_order_top
	import sjfo_pkg::*;
#(
	parameter int MAX_PEOPLE = 64,
	parameter int TIME_BITS  = 20
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire [IN_TIME_W-1:0] service_time,
	input  wire                 final_item,
	output logic                strobe,
	output logic [PERSON_W-1:0] person_number,
	output logic [WAIT_W-1:0]   wait_time,
	output logic [AVG_W-1:0]    average_wait_x100,
	output logic                dropped_flag,
	output logic                run_end
);

	localparam int CW      = $clog2(MAX_PEOPLE + 1);
	localparam int WAIT_QW = (TIME_BITS + 6 > WAIT_W) ? TIME_BITS + 6 : WAIT_W;
	localparam int TOT_W   = WAIT_QW + 6;
	localparam int NUM_W   = TOT_W + 9;
	localparam int DEN_W   = CW + 1;

	typedef enum logic [1:0] {S_LOAD, S_DRAIN, S_PREP, S_DIV} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      k_q;
	logic               ovf_q;
	logic [WAIT_QW-1:0] wait_q;
	logic [TOT_W-1:0]   total_q;
	logic [PERSON_W-1:0] last_person_q;

	logic               accept;
	logic               room;
	logic [CW-1:0]      count_next;
	logic [TIME_BITS-1:0] t_in;
	cell_ctrl_t         ctrl;

	logic [TIME_BITS-1:0] c_time   [MAX_PEOPLE];
	logic [IDX_W-1:0]     c_person [MAX_PEOPLE];
	logic                 c_gt     [MAX_PEOPLE];

	logic [NUM_W-1:0]   tot_ext;
	logic [NUM_W-1:0]   num;
	logic [DEN_W-1:0]   den;
	logic               div_done;
	logic [NUM_W-1:0]   quot;

	assign busy       = state_q != S_LOAD;
	assign accept     = start && !busy;
	assign room       = count_q < CW'(MAX_PEOPLE);
	assign count_next = room ? count_q + 1'b1 : count_q;
	assign t_in       = TIME_BITS'(service_time);

	assign ctrl.load  = accept && room;
	assign ctrl.drain = state_q == S_DRAIN;

	for (genvar i = 0; i < MAX_PEOPLE; i++) begin : g_cell
		logic [TIME_BITS-1:0] lt, rt;
		logic [IDX_W-1:0]     lp, rp;
		logic                 lg;

		if (i == 0) begin : g_first
			assign lt = t_in;
			assign lp = IDX_W'(count_q);
			assign lg = 1'b0;
		end else begin : g_mid
			assign lt = c_time[i-1];
			assign lp = c_person[i-1];
			assign lg = c_gt[i-1];
		end

		if (i == MAX_PEOPLE - 1) begin : g_last
			assign rt = c_time[i];
			assign rp = c_person[i];
		end else begin : g_inner
			assign rt = c_time[i+1];
			assign rp = c_person[i+1];
		end

		sjfo_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (CW'(i) < count_q),
			.at_end      (CW'(i) == count_q),
			.new_time    (t_in),
			.new_person  (IDX_W'(count_q)),
			.left_time   (lt),
			.left_person (lp),
			.left_gt     (lg),
			.right_time  (rt),
			.right_person(rp),
			.time_val    (c_time[i]),
			.person      (c_person[i]),
			.gt          (c_gt[i])
		);
	end

	// numerator 200*total + n, denominator 2n
	assign tot_ext = NUM_W'(total_q);
	assign num     = (tot_ext << 7) + (tot_ext << 6) + (tot_ext << 3) + NUM_W'(n_q);
	assign den     = {n_q, 1'b0};

	sjfo_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_PREP),
		.num   (num),
		.den   (den),
		.done  (div_done),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_LOAD;
			count_q           <= '0;
			n_q               <= '0;
			k_q               <= '0;
			ovf_q             <= 1'b0;
			wait_q            <= '0;
			total_q           <= '0;
			last_person_q     <= '0;
			strobe            <= 1'b0;
			person_number     <= '0;
			wait_time         <= '0;
			average_wait_x100 <= '0;
			dropped_flag      <= 1'b0;
			run_end           <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						count_q <= count_next;
						if (!room)
							ovf_q <= 1'b1;
						if (final_item) begin
							n_q     <= count_next;
							k_q     <= '0;
							wait_q  <= '0;
							total_q <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					total_q <= total_q + TOT_W'(wait_q);
					if (k_q + 1'b1 == n_q) begin
						// last word waits for the average; wait_q holds its wait
						last_person_q <= PERSON_W'(c_person[0]) + 1'b1;
						state_q       <= S_PREP;
					end else begin
						strobe            <= 1'b1;
						person_number     <= PERSON_W'(c_person[0]) + 1'b1;
						wait_time         <= wait_q[WAIT_W-1:0];
						average_wait_x100 <= '0;
						dropped_flag      <= ovf_q;
						run_end           <= 1'b0;
						wait_q            <= wait_q + WAIT_QW'(c_time[0]);
						k_q               <= k_q + 1'b1;
					end
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						strobe            <= 1'b1;
						person_number     <= last_person_q;
						wait_time         <= wait_q[WAIT_W-1:0];
						average_wait_x100 <= quot[AVG_W-1:0];
						dropped_flag      <= ovf_q;
						run_end           <= 1'b1;
						count_q           <= '0;
						ovf_q             <= 1'b0;
						state_q           <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule : shortest_job_first_order_top

`default_nettype wire

FILE: hw/rtl/sjfo_cell.sv
// ----------------------------------------------------------------------------
// sjfo_cell - one slot of the insertion chain
// Holds one time and person index; inserts, shifts right on insert, or
// shifts left while draining.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfo_cell
	import sjfo_pkg::*;
#(
	parameter int TIME_BITS = 20
) (
	input  wire                  clk,
	input  wire cell_ctrl_t      ctrl,
	input  wire                  occ,          // slot holds a stored entry
	input  wire                  at_end,       // slot is the first free one
	input  wire [TIME_BITS-1:0]  new_time,
	input  wire [IDX_W-1:0]      new_person,
	input  wire [TIME_BITS-1:0]  left_time,
	input  wire [IDX_W-1:0]      left_person,
	input  wire                  left_gt,
	input  wire [TIME_BITS-1:0]  right_time,
	input  wire [IDX_W-1:0]      right_person,
	output logic [TIME_BITS-1:0] time_val,
	output logic [IDX_W-1:0]     person,
	output logic                 gt
);

	logic [TIME_BITS-1:0] time_q;
	logic [IDX_W-1:0]     person_q;
	logic                 take;

	// strictly greater keeps ties in arrival order
	assign gt   = occ && (time_q > new_time);
	assign take = gt || at_end;

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			time_q   <= right_time;
			person_q <= right_person;
		end else if (ctrl.load && take) begin
			if (left_gt) begin
				time_q   <= left_time;
				person_q <= left_person;
			end else begin
				time_q   <= new_time;
				person_q <= new_person;
			end
		end
	end

	assign time_val = time_q;
	assign person   = person_q;

endmodule : sjfo_cell

`default_nettype wire

FILE: hw/rtl/sjfo_div.sv
// ----------------------------------------------------------------------------
// sjfo_div - restoring divider, one quotient bit per cycle
// Quotient replaces the numerator in a shared shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module sjfo_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire [NUM_W-1:0]  num,
	input  wire [DEN_W-1:0]  den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= num;
				rem_q <= '0;
				den_q <= den;
				cnt_q <= CNT_W'(NUM_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				quo_q <= {quo_q[NUM_W-2:0], fits};
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule : sjfo_div

`default_nettype wire

FILE: tb/shortest_job_first_order_top_tb.sv
// ----------------------------------------------------------------------------
// shortest_job_first_order_top_tb - self-checking bench for the SJF orderer
// Feeds service times over the start/busy command port. A software copy of
// the sorted store predicts drained results (person, wait, rounded average,
// drop mark, run end), typed rows giving their own; each strobe is checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shortest_job_first_order_top_tb;
	import sjfo_pkg::*;

	localparam int MAX_PEOPLE   = 64;
	localparam int RANDOM_WORDS = 200;
	localparam int DRAIN_WAIT   = 2 * MAX_PEOPLE + 60;

	typedef struct packed {
		logic [PERSON_W-1:0] person;
		logic [WAIT_W-1:0]   waited;
		logic [AVG_W-1:0]    avg;
		logic                dropped;
		logic                last;
	} order_result_t;

	typedef struct packed {
		logic [IN_TIME_W-1:0] t;
		logic                 f;
		logic                 typed;  // want holds the one result of a 1-person run
		order_result_t        want;
	} stim_row_t;

	localparam int PLAN_LEN = 22;
	localparam stim_row_t DIRECTED_PLAN [PLAN_LEN] = '{
		// lone person: number 1, no wait, zero average
		'{20'h00000, 1'b1, 1'b1, '{7'd1, 26'd0, 33'd0, 1'b0, 1'b1}},
		'{20'hFFFFF, 1'b1, 1'b1, '{7'd1, 26'd0, 33'd0, 1'b0, 1'b1}},
		// ties keep arrival order
		'{20'd7, 1'b0, 1'b0, '0},
		'{20'd7, 1'b0, 1'b0, '0},
		'{20'd3, 1'b0, 1'b0, '0},
		'{20'd7, 1'b1, 1'b0, '0},
		// reverse order with extremes
		'{20'hFFFFF, 1'b0, 1'b0, '0},
		'{20'h80000, 1'b0, 1'b0, '0},
		'{20'd1, 1'b0, 1'b0, '0},
		'{20'd0, 1'b1, 1'b0, '0},
		'{20'h55555, 1'b0, 1'b0, '0},
		'{20'hAAAAA, 1'b0, 1'b0, '0},
		'{20'hAAAAA, 1'b0, 1'b0, '0},
		'{20'h55555, 1'b1, 1'b0, '0},
		// already sorted
		'{20'd1, 1'b0, 1'b0, '0},
		'{20'd2, 1'b0, 1'b0, '0},
		'{20'd3, 1'b0, 1'b0, '0},
		'{20'd4, 1'b1, 1'b0, '0},
		'{20'd0, 1'b0, 1'b0, '0},
		'{20'd0, 1'b1, 1'b0, '0},
		// short pair out of order: average below one
		'{20'd3, 1'b0, 1'b0, '0},
		'{20'd1, 1'b1, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [IN_TIME_W-1:0] service_time = '0;
	logic                 final_item = 1'b0;
	wire                  busy;
	wire                  strobe;
	wire [PERSON_W-1:0]   person_number;
	wire [WAIT_W-1:0]     wait_time;
	wire [AVG_W-1:0]      average_wait_x100;
	wire                  dropped_flag;
	wire                  run_end;

	shortest_job_first_order_top #(
		.MAX_PEOPLE(MAX_PEOPLE),
		.TIME_BITS (IN_TIME_W)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.service_time     (service_time),
		.final_item       (final_item),
		.strobe           (strobe),
		.person_number    (person_number),
		.wait_time        (wait_time),
		.average_wait_x100(average_wait_x100),
		.dropped_flag     (dropped_flag),
		.run_end          (run_end)
	);

	// shadow of the sorted store
	logic [IN_TIME_W-1:0] line_times [MAX_PEOPLE];
	logic [IDX_W-1:0]     line_people [MAX_PEOPLE];
	logic [6:0]           line_count = '0;
	logic                 line_overflow = 1'b0;

	order_result_t pending_results[$];
	int mismatch_count = 0;
	int results_checked = 0;
	int words_sent = 0;
	int runs_done = 0;
	int dropped_runs = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	// insert one accepted word; on the final word compute the drained order
	task automatic order_admit(input logic [IN_TIME_W-1:0] t, input logic f,
			input bit keep_results);
		int pos;
		int k;
		longint unsigned wait_sum;
		longint unsigned total;
		longint unsigned avg_full;
		order_result_t r;
		if (line_count < MAX_PEOPLE) begin
			pos = 0;
			while (pos < line_count && line_times[pos] <= t)
				pos++;
			for (k = line_count; k > pos; k--) begin
				line_times[k]  = line_times[k-1];
				line_people[k] = line_people[k-1];
			end
			line_times[pos]  = t;
			line_people[pos] = line_count[IDX_W-1:0];
			line_count++;
		end else begin
			line_overflow = 1'b1;
		end
		if (f) begin
			wait_sum = 0;
			total = 0;
			for (k = 0; k < line_count; k++) begin
				if (k > 0)
					wait_sum += line_times[k-1];
				total += wait_sum;
				r.person  = PERSON_W'(line_people[k]) + 1'b1;
				r.waited  = wait_sum[WAIT_W-1:0];
				r.avg     = '0;
				r.dropped = line_overflow;
				r.last    = (k == line_count - 1);
				if (r.last) begin
					avg_full = (total * 200 + line_count) / (2 * line_count);
					r.avg = avg_full[AVG_W-1:0];
				end
				if (keep_results)
					pending_results.push_back(r);
			end
			runs_done++;
			if (line_overflow)
				dropped_runs++;
			line_count = '0;
			line_overflow = 1'b0;
		end
	endtask

	// one word over the start/busy port; junk on the data lines while idle
	task automatic send_word(input stim_row_t row, input bit calm);
		int gap;
		int i;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			for (i = 0; i < gap; i++) begin
				service_time <= IN_TIME_W'($urandom);
				final_item   <= 1'($urandom);
				@(posedge clk);
			end
		end
		start        <= 1'b1;
		service_time <= row.t;
		final_item   <= row.f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (row.typed)
			pending_results.push_back(row.want);
		order_admit(row.t, row.f, !row.typed);
		words_sent++;
	endtask

	always @(posedge clk) begin
		order_result_t want;
		if (arst_n && strobe) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, person_number", person_number, 0);
			end else begin
				want = pending_results.pop_front();
				if (person_number !== want.person)
					flag_mismatch("person_number", person_number, want.person);
				if (wait_time !== want.waited)
					flag_mismatch("wait_time", wait_time, want.waited);
				if (average_wait_x100 !== want.avg)
					flag_mismatch("average_wait_x100", average_wait_x100, want.avg);
				if (dropped_flag !== want.dropped)
					flag_mismatch("dropped_flag", dropped_flag, want.dropped);
				if (run_end !== want.last)
					flag_mismatch("run_end", run_end, want.last);
			end
		end
	end

	initial begin
		stim_row_t row;
		int run_idx;
		int len;
		int j;
		bit narrow;
		bit calm;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (j = 0; j < PLAN_LEN; j++)
			send_word(DIRECTED_PLAN[j], j < 10);

		// random runs; one fills the store exactly, one overflows it
		run_idx = 0;
		while (words_sent < PLAN_LEN + RANDOM_WORDS) begin
			if (run_idx == 2)
				len = MAX_PEOPLE;
			else if (run_idx == 5)
				len = MAX_PEOPLE + $urandom_range(1, 4);
			else
				len = $urandom_range(1, 12);
			narrow = ($urandom_range(0, 3) == 0);
			calm   = ($urandom_range(0, 3) == 0);
			for (j = 0; j < len; j++) begin
				row = '0;
				if (narrow)
					row.t = IN_TIME_W'($urandom_range(0, 7));
				else
					case ($urandom_range(0, 7))
						0: row.t = '0;
						1: row.t = '1;
						default: row.t = IN_TIME_W'($urandom);
					endcase
				row.f = (j == len - 1);
				send_word(row, calm);
			end
			run_idx++;
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never seen, count", pending_results.size(), 0);

		$display("covered %0d words in %0d runs (%0d with drops), %0d results checked",
			words_sent, runs_done, dropped_runs, results_checked);
		if (mismatch_count == 0) begin
			$display("shortest_job_first_order_top regression: pass");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("shortest_job_first_order_top regression: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timed out with %0d results outstanding", pending_results.size());
		$display("shortest_job_first_order_top regression: fail");
		$finish;
	end

endmodule
